>>> hw/rtl/gpcst_pkg.sv
package gpcst_pkg;

    localparam int POLY_MAX_W = 32;
    localparam int SHORT_W    = 12;
    localparam int FULL_W     = 13;
    localparam int WORD_W     = 32;
    localparam int RUN_W      = 6;
    localparam int DEG_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int PLEN_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 1'b1;

    localparam logic [PLEN_W-1:0]  PLEN_RESET  = 6'd20;
    localparam logic [PLEN_W-1:0]  PLEN_MAX    = 6'd32;
    localparam logic [SHORT_W-1:0] LIMIT_RESET = 12'd1023;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

    typedef struct packed {
        logic [SHORT_W-1:0]  short_steps;
        logic [FULL_W-1:0]   full_steps;
        logic [WORD_W-1:0]   parity_word;
        logic [RUN_W-1:0]    odd_run;
        logic [DEG_W-1:0]    degree;
        logic [STATUS_W-1:0] status;
    } gpcst_result_t;

endpackage

>>> hw/rtl/gpcst_map_unit.sv
module gpcst_map_unit
    import gpcst_pkg::*;
#(
    parameter int VAL_W = 32
)
(
    input  logic [VAL_W-1:0] val,
    output logic [VAL_W-1:0] val_next,
    output logic             is_one,
    output logic             odd
);

    logic [VAL_W-1:0] one_w;

    assign one_w  = VAL_W'(1);
    assign odd    = val[0];
    assign is_one = (val == one_w);

    // even: divide by x, odd: f xor ((f xor 1) / x)
    always_comb
    begin
        if (val[0])
        begin
            val_next = val ^ ((val ^ one_w) >> 1);
        end
        else
        begin
            val_next = val >> 1;
        end
    end

endmodule

>>> hw/rtl/gpcst_seq.sv
module gpcst_seq
    import gpcst_pkg::*;
#(
    parameter int VAL_W = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VAL_W-1:0]      poly_in,
    input  logic [PLEN_W-1:0]     parity_len,
    input  logic [SHORT_W-1:0]    step_limit,
    output logic                  idle,
    output logic                  res_valid,
    input  logic                  res_ack,
    output gpcst_result_t         res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [VAL_W-1:0]    f0_reg, f0_next;
    logic [SHORT_W-1:0]  short_reg, short_next;
    logic [FULL_W-1:0]   full_reg, full_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [PLEN_W-1:0]   pcnt_reg, pcnt_next;
    logic                active_reg, active_next;
    logic                lim_reg, lim_next;
    logic                zero_reg, zero_next;

    logic [VAL_W-1:0]    map_out;
    logic                map_one;
    logic                map_odd;
    logic [PLEN_W-1:0]   plen;
    logic [POLY_MAX_W-1:0] f0_32;
    logic [POLY_MAX_W-1:0] tz_src;

    gpcst_map_unit #(
        .VAL_W (VAL_W)
    ) u_map (
        .val      (val_reg),
        .val_next (map_out),
        .is_one   (map_one),
        .odd      (map_odd)
    );

    function automatic logic [DEG_W-1:0] msb_pos(input logic [POLY_MAX_W-1:0] v);
        logic [DEG_W-1:0] p;
        p = '0;
        for (int i = 0; i < POLY_MAX_W; i++)
        begin
            if (v[i])
            begin
                p = DEG_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [RUN_W-1:0] tz_count(input logic [POLY_MAX_W-1:0] v);
        logic [RUN_W-1:0] n;
        n = RUN_W'(POLY_MAX_W);
        for (int i = POLY_MAX_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = RUN_W'(i);
            end
        end
        return n;
    endfunction

    assign plen   = (parity_len > PLEN_MAX) ? PLEN_MAX : parity_len;
    assign f0_32  = POLY_MAX_W'(f0_reg);
    assign tz_src = f0_32 ^ POLY_MAX_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        val_next    = val_reg;
        f0_next     = f0_reg;
        short_next  = short_reg;
        full_next   = full_reg;
        word_next   = word_reg;
        pcnt_next   = pcnt_reg;
        active_next = active_reg;
        lim_next    = lim_reg;
        zero_next   = zero_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next    = poly_in;
                    f0_next     = poly_in;
                    short_next  = '0;
                    full_next   = '0;
                    word_next   = '0;
                    pcnt_next   = '0;
                    active_next = 1'b1;
                    lim_next    = 1'b0;
                    zero_next   = (poly_in == '0);
                    state_next  = (poly_in == '0) ? S_DONE : S_RUN;
                end
            end
            S_RUN:
            begin
                // parity bit for this iterate
                if (pcnt_reg < plen)
                begin
                    word_next[pcnt_reg[DEG_W-1:0]] = val_reg[0];
                    pcnt_next = pcnt_reg + PLEN_W'(1);
                end
                // stopping time walk
                if (active_reg)
                begin
                    if (map_one)
                    begin
                        active_next = 1'b0;
                    end
                    else if (short_reg >= step_limit)
                    begin
                        active_next = 1'b0;
                        lim_next    = 1'b1;
                    end
                    else
                    begin
                        short_next = short_reg + SHORT_W'(1);
                        full_next  = full_reg + (map_odd ? FULL_W'(2) : FULL_W'(1));
                    end
                end
                val_next = map_out;
                if (!active_next && (pcnt_next >= plen))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= 1'b0;
            lim_reg    <= 1'b0;
            zero_reg   <= 1'b0;
            pcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            lim_reg    <= lim_next;
            zero_reg   <= zero_next;
            pcnt_reg   <= pcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        f0_reg    <= f0_next;
        short_reg <= short_next;
        full_reg  <= full_next;
        word_reg  <= word_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.short_steps = short_reg;
        res.full_steps  = full_reg;
        res.parity_word = word_reg;
        res.odd_run     = zero_reg ? '0 : tz_count(tz_src);
        res.degree      = msb_pos(f0_32);
        if (zero_reg)
        begin
            res.status = ST_ZERO;
        end
        else if (lim_reg)
        begin
            res.status = ST_LIMIT;
        end
        else
        begin
            res.status = ST_OK;
        end
    end

endmodule

>>> hw/rtl/gf2_poly_collatz_stopping_time_top.sv
// Stopping time of the shortcut Collatz-like map on binary polynomials over F2.
// One polynomial word goes in, one result word comes out. A single map unit makes
// one shortcut step per cycle; an item iterates until its walk has stopped and P
// parity bits are written, where P is parity_len capped at 32; the result is then
// handed to the output register, and a zero polynomial skips the iteration. in_ready
// is low while an item iterates; the next item may be taken
// while the previous result still waits in the output register. Only the low
// min(POLY_WIDTH, 32) bits of poly are used. Configuration writes are always
// taken and are meant to happen only while the block is idle.
module gf2_poly_collatz_stopping_time_top
    import gpcst_pkg::*;
#(
    parameter int POLY_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [POLY_MAX_W-1:0] poly,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SHORT_W-1:0]    short_steps,
    output logic [FULL_W-1:0]     full_steps,
    output logic [WORD_W-1:0]     parity_word,
    output logic [RUN_W-1:0]      odd_run,
    output logic [DEG_W-1:0]      degree,
    output logic [STATUS_W-1:0]   status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int VAL_W = (POLY_WIDTH < POLY_MAX_W) ? POLY_WIDTH : POLY_MAX_W;

    logic [PLEN_W-1:0]  plen_reg, plen_next;
    logic [SHORT_W-1:0] limit_reg, limit_next;
    logic               out_valid_reg, out_valid_next;
    gpcst_result_t      out_reg, out_next;

    logic               seq_idle;
    logic               res_valid;
    logic               res_ack;
    gpcst_result_t      res;

    gpcst_seq #(
        .VAL_W (VAL_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid && in_ready),
        .poly_in    (poly[VAL_W-1:0]),
        .parity_len (plen_reg),
        .step_limit (limit_reg),
        .idle       (seq_idle),
        .res_valid  (res_valid),
        .res_ack    (res_ack),
        .res        (res)
    );

    assign in_ready  = seq_idle;
    assign cfg_ready = 1'b1;

    // config registers
    always_comb
    begin
        plen_next  = plen_reg;
        limit_next = limit_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PARITY_LEN: plen_next  = cfg_data[PLEN_W-1:0];
                CFG_STEP_LIMIT: limit_next = cfg_data[SHORT_W-1:0];
                default:        ;
            endcase
        end
    end

    // output register
    assign res_ack = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_ack)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= PLEN_RESET;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg      <= plen_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign short_steps = out_reg.short_steps;
    assign full_steps  = out_reg.full_steps;
    assign parity_word = out_reg.parity_word;
    assign odd_run     = out_reg.odd_run;
    assign degree      = out_reg.degree;
    assign status      = out_reg.status;

endmodule

>>> dv/gf2_poly_collatz_stopping_time_top_tb.sv
`timescale 1ns / 100ps

module gf2_poly_collatz_stopping_time_top_tb;

    import gpcst_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [POLY_MAX_W-1:0] poly;
    logic                  out_valid;
    logic                  out_ready;
    logic [SHORT_W-1:0]    short_steps;
    logic [FULL_W-1:0]     full_steps;
    logic [WORD_W-1:0]     parity_word;
    logic [RUN_W-1:0]      odd_run;
    logic [DEG_W-1:0]      degree;
    logic [STATUS_W-1:0]   status;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [PLEN_W-1:0]     cfg_plen;
    logic [SHORT_W-1:0]    cfg_limit;
    gpcst_result_t         pending_orbits[$];

    bit in_gaps;
    bit out_stalls;
    int out_hold_cycles;
    int mismatch_count;
    int polys_sent;
    int results_seen;
    int arrived_count;
    int zero_count;
    int limit_count;
    int settings_count;

    gf2_poly_collatz_stopping_time_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .poly        (poly),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .short_steps (short_steps),
        .full_steps  (full_steps),
        .parity_word (parity_word),
        .odd_run     (odd_run),
        .degree      (degree),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [31:0] map_step(input logic [31:0] f);
        return f[0] ? (f ^ ((f ^ 32'd1) >> 1)) : (f >> 1);
    endfunction

    function automatic gpcst_result_t predict_orbit(input logic [31:0] p);
        gpcst_result_t r;
        logic [31:0]   g;
        int            plen;
        int            n;
        r = '0;
        if (p == 32'd0)
        begin
            r.status = ST_ZERO;
            return r;
        end
        for (n = 0; n < 32; n++)
            if (p[n])
                r.degree = n[DEG_W-1:0];
        g = p ^ 32'd1;
        if (g == 32'd0)
            r.odd_run = 6'd32;
        else
        begin
            n = 0;
            while (!g[n])
                n++;
            r.odd_run = n[RUN_W-1:0];
        end
        plen = (cfg_plen > PLEN_MAX) ? int'(PLEN_MAX) : int'(cfg_plen);
        g = p;
        for (n = 0; n < plen; n++)
        begin
            r.parity_word[n] = g[0];
            g = map_step(g);
        end
        g = p;
        r.status = ST_OK;
        while (g != 32'd1)
        begin
            if (r.short_steps >= cfg_limit)
            begin
                r.status = ST_LIMIT;
                break;
            end
            r.full_steps  = r.full_steps + (g[0] ? 13'd2 : 13'd1);
            r.short_steps = r.short_steps + 12'd1;
            g = map_step(g);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // input word accepted: predict its result
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            pending_orbits.push_back(predict_orbit(poly));
            polys_sent++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PARITY_LEN: cfg_plen = cfg_data[PLEN_W-1:0];
                CFG_STEP_LIMIT: cfg_limit = cfg_data[SHORT_W-1:0];
                default: ;
            endcase
        end
    end

    // output word accepted: compare with oldest prediction
    always @(posedge clk)
    begin
        gpcst_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_orbits.size() == 0)
                report_mismatch("result word with no polynomial outstanding");
            else
            begin
                want = pending_orbits.pop_front();
                if (short_steps !== want.short_steps)
                    report_mismatch($sformatf("short_steps %0d, want %0d",
                                              short_steps, want.short_steps));
                if (full_steps !== want.full_steps)
                    report_mismatch($sformatf("full_steps %0d, want %0d",
                                              full_steps, want.full_steps));
                if (parity_word !== want.parity_word)
                    report_mismatch($sformatf("parity_word %h, want %h",
                                              parity_word, want.parity_word));
                if (odd_run !== want.odd_run)
                    report_mismatch($sformatf("odd_run %0d, want %0d",
                                              odd_run, want.odd_run));
                if (degree !== want.degree)
                    report_mismatch($sformatf("degree %0d, want %0d",
                                              degree, want.degree));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              status, want.status));
                case (want.status)
                    ST_OK:    arrived_count++;
                    ST_ZERO:  zero_count++;
                    ST_LIMIT: limit_count++;
                    default: ;
                endcase
            end
        end
    end

    // receiver, with an optional counted hold-off
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                out_hold_cycles--;
            end
            else
                out_ready <= !(out_stalls && $urandom_range(0, 99) < 6);
        end
    end

    task automatic send_poly(input logic [31:0] p);
        while (in_gaps && $urandom_range(0, 99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        poly     <= p;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_orbits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] plen_data,
                              input logic [CFG_DATA_W-1:0] limit_data);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PARITY_LEN;
        cfg_data  <= plen_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_STEP_LIMIT;
        cfg_data  <= limit_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_count++;
    endtask

    function automatic logic [31:0] rand_poly();
        logic [31:0] p;
        int          d;
        p = $urandom();
        case ($urandom_range(0, 9))
            1, 2:
            begin
                d = $urandom_range(0, 31);
                p = p >> (31 - d);
                p[d] = 1'b1;
            end
            3:
            begin
                p = 32'd0;
                repeat ($urandom_range(1, 3))
                    p[$urandom_range(0, 31)] = 1'b1;
            end
            4:
            begin
                d = $urandom_range(1, 31);
                p = (p << d) | 32'd1;
            end
            5:
            begin
                case ($urandom_range(0, 4))
                    0: p = 32'd0;
                    1: p = 32'd1;
                    2: p = 32'hFFFF_FFFF;
                    3: p = 32'h8000_0000;
                    default: p = 32'd2;
                endcase
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic test_directed();
        logic [31:0] edge_polys[14];
        edge_polys = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000,
                       32'h8000_0001, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                       32'hFFFF_FFFE, 32'h0000_0010, 32'h1234_5678, 32'hDEAD_BEEF};
        foreach (edge_polys[i])
            send_poly(edge_polys[i]);
        set_config(12'd32, 12'd4095);
        send_poly(32'hFFFF_FFFF);
        send_poly(32'h8000_0001);
        // short limit: 4 is flagged before arrival, 2 arrives at the limit
        set_config(12'd1, 12'd1);
        send_poly(32'h0000_0004);
        send_poly(32'd2);
        // zero limit and zero parity length
        set_config(12'd0, 12'd0);
        send_poly(32'd1);
        send_poly(32'd5);
        send_poly(32'd0);
        // parity length above 32, upper data bits set
        set_config(12'hFFF, 12'd7);
        send_poly(32'hC000_0003);
        send_poly(32'd1);
    endtask

    task automatic test_random_settings();
        logic [5:0]  plens[6];
        logic [11:0] limits[6];
        plens  = '{6'd32, 6'd1, 6'd63, 6'd7, 6'($urandom_range(0, 63)), 6'd20};
        limits = '{12'd4095, 12'd1023, 12'd25, 12'd1, 12'($urandom_range(1, 4095)),
                   12'd300};
        in_gaps    = 1'b1;
        out_stalls = 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            set_config({6'($urandom_range(0, 63)), plens[ph]}, limits[ph]);
            repeat (85)
                send_poly(rand_poly());
        end
    endtask

    task automatic test_output_hold();
        set_config(12'd20, 12'd1023);
        out_hold_cycles = 400;
        repeat (12)
            send_poly(rand_poly());
        wait_all_results();
    endtask

    task automatic test_streaming();
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
        set_config(12'd32, 12'd4095);
        repeat (100)
            send_poly(rand_poly());
        wait_all_results();
        in_gaps    = 1'b1;
        out_stalls = 1'b1;
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        poly       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_PARITY_LEN;
        cfg_data   <= '0;
        cfg_plen    = PLEN_RESET;
        cfg_limit   = LIMIT_RESET;
        in_gaps     = 1'b1;
        out_stalls  = 1'b1;
        out_hold_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_settings();
        test_output_hold();
        test_streaming();

        wait_all_results();
        repeat (50) @(posedge clk);
        if (pending_orbits.size() != 0)
            report_mismatch("results still outstanding at end of run");

        $display("%0d polynomials sent, %0d checked across %0d register settings",
                 polys_sent, results_seen, settings_count + 1);
        $display("%0d reached one, %0d zero inputs, %0d stopped at the step limit",
                 arrived_count, zero_count, limit_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
